/* rtl/rwa_pkg.sv */
package rwa_pkg;

  localparam int DEF_MAX_PARTICLES = 64;

  localparam int FIT_W      = 32;
  localparam int PIDX_W     = 6;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 7;
  localparam int RADIUS_W   = 5;

  localparam logic [COUNT_W-1:0]  RST_COUNT    = 7'd64;
  localparam logic [RADIUS_W-1:0] RST_RADIUS   = 5'd1;
  localparam logic [FIT_W-1:0]    RST_SENTINEL = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT    = 2'd0,
    CFG_RADIUS   = 2'd1,
    CFG_SENTINEL = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

/* rtl/rwa_ram.sv */
module rwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ring_window_argmin.sv */
// Ring-window minimum search over a batch of particle fitness values.
//
// Input stream (s_axis_*): one signed Q16.16 fitness per transaction, taken in
// particle order 0, 1, 2, ... Each accepted value is written to the fitness
// RAM in the cycle it arrives, so loading runs at one transaction per cycle.
// When the transaction for the last particle of the configured count arrives,
// the block stops accepting input and scans: for each particle it reads the
// 2r+1 entries of its circular window through the single RAM read port and
// folds them through one signed comparator. Per particle it issues the reads
// (ST_READ), finishes the last compare (ST_DRAIN) and loads the output
// register (ST_EMIT); r is the radius clamped to (count-1)/2.
// Output stream (m_axis_*): one result per particle in index order, tlast on
// the final one. A stalled receiver holds the result in the output register
// and the scan waits for it. Input is accepted again as soon as the final
// result has entered the output register.
// Configuration (cfg_*): always ready; write only while the block is idle.
// Reset sets count 64, radius 1, sentinel 0x7FFFFFFF and an empty batch. The
// RAM is not cleared; every entry of a batch is written before it is read.
module ring_window_argmin
  import rwa_pkg::*;
#(
  parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Fitness input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [FIT_W-1:0]      s_axis_tdata,   // [31:0] fitness
  // Result output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] particle_index,
                                                // [11:6] best_index,
                                                // [43:12] best_fitness,
                                                // [47:44] zero
  output logic                  m_axis_tlast    // last_result
);

  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] n);
    if (CNT_W'(idx) + CNT_W'(1) == n) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

  // Configuration registers.
  logic [COUNT_W-1:0]  cfg_count_q;
  logic [RADIUS_W-1:0] cfg_radius_q;
  logic [FIT_W-1:0]    cfg_sent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q  <= RST_COUNT;
      cfg_radius_q <= RST_RADIUS;
      cfg_sent_q   <= RST_SENTINEL;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COUNT:    cfg_count_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_RADIUS:   cfg_radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_SENTINEL: cfg_sent_q   <= cfg_data_i[FIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Effective count and clamped radius.
  logic [31:0]      cnt_ext;
  logic [CNT_W-1:0] n_c;
  logic [CNT_W-1:0] half_c;
  logic [CNT_W-1:0] r_c;
  logic [CNT_W-1:0] diff_c;
  logic [IDX_W-1:0] start0_c;

  always_comb begin
    cnt_ext = 32'(cfg_count_q);
    if (cnt_ext == 32'd0) begin
      n_c = CNT_W'(1);
    end else if (cnt_ext > 32'(MAX_PARTICLES)) begin
      n_c = CNT_W'(MAX_PARTICLES);
    end else begin
      n_c = CNT_W'(cnt_ext);
    end
    half_c = (n_c - CNT_W'(1)) >> 1;
    if (32'(cfg_radius_q) > 32'(half_c)) begin
      r_c = half_c;
    end else begin
      r_c = CNT_W'(cfg_radius_q);
    end
    diff_c   = n_c - r_c;
    start0_c = (diff_c == n_c) ? '0 : IDX_W'(diff_c);
  end

  // Sequencer state.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0] p_q, p_d;
  logic [IDX_W-1:0] start_q, start_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] k_q, k_d;

  logic             in_acc;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] load_next;
  logic             batch_full;
  logic             read_last;
  logic             part_last;
  logic             out_free;
  logic             emit;
  logic [FIT_W-1:0] rd_data;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_idx        = (load_cnt_q >= n_c) ? '0 : IDX_W'(load_cnt_q);
  assign load_next     = CNT_W'(wr_idx) + CNT_W'(1);
  assign batch_full    = (load_next == n_c);
  assign read_last     = ((CNT_W + 1)'(k_q) == {r_c, 1'b0});
  assign part_last     = (CNT_W'(p_q) + CNT_W'(1) == n_c);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = (state_q == ST_EMIT) && out_free;

  rwa_ram #(
    .WIDTH (FIT_W),
    .DEPTH (MAX_PARTICLES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wr_idx),
    .wdata_i (s_axis_tdata),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && batch_full) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (read_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = part_last ? ST_LOAD : ST_READ;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Counters and read addresses.
  always_comb begin
    load_cnt_d = load_cnt_q;
    p_d        = p_q;
    start_d    = start_q;
    rd_idx_d   = rd_idx_q;
    k_d        = k_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (batch_full) begin
            load_cnt_d = '0;
            p_d        = '0;
            start_d    = start0_c;
            rd_idx_d   = start0_c;
            k_d        = '0;
          end else begin
            load_cnt_d = load_next;
          end
        end
      end
      ST_READ: begin
        rd_idx_d = next_idx(rd_idx_q, n_c);
        k_d      = k_q + CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_free && !part_last) begin
          p_d      = p_q + IDX_W'(1);
          start_d  = next_idx(start_q, n_c);
          rd_idx_d = next_idx(start_q, n_c);
          k_d      = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      p_q        <= '0;
      start_q    <= '0;
      rd_idx_q   <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      p_q        <= p_d;
      start_q    <= start_d;
      rd_idx_q   <= rd_idx_d;
      k_q        <= k_d;
    end
  end

  // Compare stage, working on the read address of the previous cycle.
  logic                    cmp_vld_q;
  logic                    cmp_first_q;
  logic [IDX_W-1:0]        cmp_idx_q;
  logic signed [FIT_W-1:0] best_val_q, best_val_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic                    hit_q, hit_d;
  logic signed [FIT_W-1:0] fall_val_q, fall_val_d;

  logic signed [FIT_W-1:0] cand;
  logic signed [FIT_W-1:0] base_val;
  logic [IDX_W-1:0]        base_idx;
  logic                    base_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q   <= 1'b0;
      cmp_first_q <= 1'b0;
    end else begin
      cmp_vld_q   <= (state_q == ST_READ);
      cmp_first_q <= (state_q == ST_READ) && (k_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_idx_q;
  end

  // The window start seeds the search with the sentinel, so a value only wins
  // when it is strictly below everything seen so far, which keeps ties early.
  always_comb begin
    cand     = signed'(rd_data);
    base_val = cmp_first_q ? signed'(cfg_sent_q) : best_val_q;
    base_idx = cmp_first_q ? cmp_idx_q : best_idx_q;
    base_hit = cmp_first_q ? 1'b0 : hit_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    hit_d      = hit_q;
    fall_val_d = fall_val_q;
    if (cmp_vld_q) begin
      if (cand < base_val) begin
        best_val_d = cand;
        best_idx_d = cmp_idx_q;
        hit_d      = 1'b1;
      end else begin
        best_val_d = base_val;
        best_idx_d = base_idx;
        hit_d      = base_hit;
      end
      if (cmp_first_q) begin
        fall_val_d = cand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    hit_q      <= hit_d;
    fall_val_q <= fall_val_d;
  end

  // Output register.
  logic              out_vld_q, out_vld_d;
  logic [PIDX_W-1:0] out_pidx_q;
  logic [PIDX_W-1:0] out_bidx_q;
  logic [FIT_W-1:0]  out_fit_q;
  logic              out_last_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pidx_q <= PIDX_W'(p_q);
      out_bidx_q <= PIDX_W'(best_idx_q);
      out_fit_q  <= hit_q ? best_val_q : fall_val_q;
      out_last_q <= part_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_DATA_W - FIT_W - 2 * PIDX_W)'(0), out_fit_q,
                          out_bidx_q, out_pidx_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/rwa_checker.sv */
module rwa_checker
  import rwa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [FIT_W-1:0]      s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // A result that waits keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // While a batch is still being reported, no new fitness is taken.
  a_no_load_mid_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted before the batch was fully reported");

  // After a result that is not the final one, the scan is still running, unless
  // the final result moved into the output register in the same cycle.
  a_scan_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !s_axis_tready || (m_axis_tvalid && m_axis_tlast))
    else $error("input ready right after a non-final result");

  // Configuration writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind ring_window_argmin rwa_checker u_rwa_checker (.*);

/* sim/ring_window_argmin_checker.sv */
module ring_window_argmin_checker
  import rwa_pkg::*;
#(
  parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  fit_valid_i,
  input  logic                  fit_ready_i,
  input  logic [FIT_W-1:0]      fit_data_i,   // [31:0] fitness
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_DATA_W-1:0] res_data_i,   // [5:0] particle_index, [11:6] best_index,
                                              // [43:12] best_fitness, [47:44] zero
  input  logic                  res_last_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    batches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PIDX_W-1:0] particle;
    logic [PIDX_W-1:0] best_idx;
    logic [FIT_W-1:0]  best_fit;
    logic              last;
  } window_min_t;

  logic [FIT_W-1:0]    fit_mem [MAX_PARTICLES];
  int unsigned         fill;
  logic [COUNT_W-1:0]  count_reg;
  logic [RADIUS_W-1:0] radius_reg;
  logic [FIT_W-1:0]    sentinel_reg;
  window_min_t         window_min_q [$];
  int                  errors  = 0;
  int                  results = 0;
  int                  batches = 0;

  // Stores one fitness; when the batch is complete, queues the minimum of every
  // particle's circular window in particle order.
  task automatic load_fitness(input logic [FIT_W-1:0] value);
    int unsigned             ring;
    int unsigned             reach;
    int unsigned             first;
    int unsigned             idx;
    int unsigned             p;
    int unsigned             k;
    logic signed [FIT_W-1:0] low;
    window_min_t             entry;
    ring = count_reg;
    if (ring == 0) ring = 1;
    if (ring > MAX_PARTICLES) ring = MAX_PARTICLES;
    // A count lowered to or below the size of the partial batch restarts the batch at particle 0.
    if (fill >= ring) fill = 0;
    fit_mem[fill] = value;
    fill++;
    if (fill == ring) begin
      fill = 0;
      batches++;
      reach = radius_reg;
      if (reach > (ring - 1) / 2) reach = (ring - 1) / 2;
      for (p = 0; p < ring; p++) begin
        first = (p + ring - reach) % ring;
        // With nothing below the sentinel the window start is reported.
        entry.best_idx = PIDX_W'(first);
        low = sentinel_reg;
        for (k = 0; k <= 2 * reach; k++) begin
          idx = (first + k) % ring;
          if ($signed(fit_mem[idx]) < low) begin
            low = fit_mem[idx];
            entry.best_idx = PIDX_W'(idx);
          end
        end
        entry.particle = PIDX_W'(p);
        entry.best_fit = fit_mem[entry.best_idx];
        entry.last     = (p == ring - 1);
        window_min_q.push_back(entry);
      end
    end
  endtask

  task automatic check_result();
    window_min_t got;
    window_min_t want;
    got.particle = res_data_i[PIDX_W-1:0];
    got.best_idx = res_data_i[2*PIDX_W-1:PIDX_W];
    got.best_fit = res_data_i[2*PIDX_W+FIT_W-1:2*PIDX_W];
    got.last     = res_last_i;
    results++;
    if (window_min_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected result particle %0d best %0d fitness %h last %b",
                 $time, got.particle, got.best_idx, got.best_fit, got.last);
    end else begin
      want = window_min_q.pop_front();
      if (got.particle !== want.particle || got.best_idx !== want.best_idx ||
          got.best_fit !== want.best_fit || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch expected particle %0d best %0d fitness %h last %b, %s",
                   $time, want.particle, want.best_idx, want.best_fit, want.last,
                   $sformatf("got particle %0d best %0d fitness %h last %b",
                             got.particle, got.best_idx, got.best_fit, got.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (fit_mem[i]) fit_mem[i] = '0;
      fill         = 0;
      count_reg    = RST_COUNT;
      radius_reg   = RST_RADIUS;
      sentinel_reg = RST_SENTINEL;
      window_min_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_COUNT:    count_reg    = cfg_data_i[COUNT_W-1:0];
          CFG_RADIUS:   radius_reg   = cfg_data_i[RADIUS_W-1:0];
          CFG_SENTINEL: sentinel_reg = cfg_data_i[FIT_W-1:0];
          default: ;
        endcase
      end
      if (fit_valid_i && fit_ready_i) load_fitness(fit_data_i);
      if (res_valid_i && res_ready_i) check_result();
    end
    errors_o  <= errors;
    pending_o <= window_min_q.size();
    results_o <= results;
    batches_o <= batches;
  end

endmodule

/* sim/ring_window_argmin_tb.sv */
module ring_window_argmin_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rwa_pkg::*;

  localparam int CLK_HALF_NS   = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_PARTICLES = DEF_MAX_PARTICLES;
  localparam int RANDOM_ITEMS  = 96;
  localparam int IDLE_PAUSE    = 10;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 400;
  localparam int WATCHDOG_NS   = 5_000_000;

  // Styles of random fitness content.
  localparam int FIT_WIDE   = 0;
  localparam int FIT_NARROW = 1;
  localparam int FIT_EDGY   = 2;

  // Register index past the end of the map; writes to it are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [FIT_W-1:0]      s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int errors;
  int pending;
  int results;
  int batches;
  int items_sent      = 0;
  int settings        = 0;
  int long_holds_done = 0;
  bit long_hold_wanted = 1'b0;
  bit sender_steady    = 1'b0;

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  ring_window_argmin #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  ring_window_argmin_checker #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fit_valid_i(s_axis_tvalid),
    .fit_ready_i(s_axis_tready),
    .fit_data_i (s_axis_tdata),
    .res_valid_i(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_data_i (m_axis_tdata),
    .res_last_i (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .batches_o  (batches)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIT_W-1:0] pick_fitness(input int style,
                                                   input logic [FIT_W-1:0] sent);
    case (style)
      FIT_NARROW: return FIT_W'(int'($urandom_range(0, 16)) - 8);
      FIT_EDGY: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return sent;
          3:       return sent - 1;
          4:       return sent + 1;
          default: return $urandom();
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Count and radius carry random bits above their fields, which must be ignored.
  task automatic set_config(input int cnt, input int rad, input logic [FIT_W-1:0] sent);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom();
    word[COUNT_W-1:0] = COUNT_W'(cnt);
    write_reg(CFG_COUNT, word);
    word = $urandom();
    word[RADIUS_W-1:0] = RADIUS_W'(rad);
    write_reg(CFG_RADIUS, word);
    write_reg(CFG_SENTINEL, sent);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic feed(input logic [FIT_W-1:0] vals [$]);
    int gap;
    foreach (vals[i]) begin
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= vals[i];
      do @(posedge clk_i); while (!s_axis_tready);
      items_sent++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // The count seen here comes from a register behind the checker's queue, hence the first edge.
  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int gap;
    int run;
    run = 1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_wanted && long_holds_done == 0 && m_axis_tvalid) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
        long_holds_done++;
      end else if (run > 0) begin
        m_axis_tready <= 1'b1;
        run--;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
        end
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      end
    end
  end

  initial begin : stimulus
    logic [FIT_W-1:0] vals [$];
    logic [FIT_W-1:0] sent;
    int               ph;
    int               roll;
    int               cnt;
    int               rad;
    int               ring;
    int               span;
    int               style;
    int               random_items;
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // Field extremes with a plain window.
    set_config(4, 1, RST_SENTINEL);
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    feed(vals);
    settle();
    // Equal minima: the one nearest the window start wins; radius is clamped to 2.
    set_config(5, 31, RST_SENTINEL);
    vals = '{32'd9, 32'd2, 32'd7, 32'd2, 32'd2};
    feed(vals);
    settle();
    // Nothing can be below the most negative sentinel.
    set_config(3, 1, 32'h8000_0000);
    vals = '{32'h8000_0000, 32'd5, 32'hFFFF_FFFF};
    feed(vals);
    settle();
    // Values equal to the sentinel are not chosen; zero radius.
    set_config(3, 0, 32'd5);
    vals = '{32'd5, 32'd4, 32'd6};
    feed(vals);
    settle();
    // A count of zero acts as a single particle.
    set_config(0, 31, RST_SENTINEL);
    vals = '{32'h1234_5678};
    feed(vals);
    settle();
    // Lowering the count under a partial batch drops it.
    set_config(6, 1, RST_SENTINEL);
    vals = '{32'h0000_0010, 32'hFFFF_FFF0, 32'h0001_0000, 32'h7FFF_FFFE};
    feed(vals);
    settle();
    write_reg(CFG_COUNT, 32'd2);
    write_reg(CFG_SPARE, $urandom());
    cfg_valid_i <= 1'b0;
    vals = '{32'h0000_0042, 32'hFFFF_0000};
    feed(vals);
    settle();

    for (ph = 0; random_items < RANDOM_ITEMS; ph++) begin
      if (ph == 0) begin
        // Count above the maximum with the widest window.
        cnt  = 127;
        rad  = 31;
        sent = $urandom();
      end else if (ph == 1) begin
        cnt  = 8;
        rad  = $urandom_range(0, 3);
        sent = RST_SENTINEL;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 72) cnt = $urandom_range(1, 12);
        else if (roll < 90) cnt = $urandom_range(13, 40);
        else if (roll < 93) cnt = 64;
        else if (roll < 95) cnt = $urandom_range(65, 127);
        else cnt = 0;
        roll = $urandom_range(0, 99);
        if (roll < 20) rad = 0;
        else if (roll < 35) rad = 31;
        else if (roll < 70) rad = $urandom_range(0, 8);
        else rad = $urandom_range(0, 31);
        roll = $urandom_range(0, 99);
        if (roll < 55) sent = RST_SENTINEL;
        else if (roll < 70) sent = $urandom();
        else if (roll < 80) sent = 32'h8000_0000;
        else sent = FIT_W'(int'($urandom_range(0, 16)) - 8);
      end
      ring = (cnt == 0) ? 1 : (cnt > MAX_PARTICLES) ? MAX_PARTICLES : cnt;
      span = (ring >= 40) ? ring : ring * $urandom_range(1, 3);
      if (ph == 1) span = 2 * ring;
      else if (ring > 1 && $urandom_range(0, 4) == 0) span += $urandom_range(1, ring - 1);
      style = (ph == 0) ? FIT_WIDE : $urandom_range(FIT_WIDE, FIT_EDGY);
      vals.delete();
      repeat (span) vals.push_back(pick_fitness(style, sent));

      // In the second phase the receiver stalls on the first result while the
      // next batch is offered without pause.
      sender_steady    = (ph == 1) || ($urandom_range(0, 3) == 0);
      long_hold_wanted = long_hold_wanted || (ph == 1);
      set_config(cnt, rad, sent);
      feed(vals);
      random_items += span;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d fitness loads under %0d register settings, %0d window results",
             items_sent, settings, results);
    $display("in %0d batches; receiver long holds: %0d; mismatches: %0d.",
             batches, long_holds_done, errors);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Timed out with %0d results outstanding.", pending);
    $display("status: fail");
    $finish;
  end

endmodule

/* ring_window_argmin.f */
rtl/rwa_pkg.sv
rtl/rwa_ram.sv
rtl/ring_window_argmin.sv
rtl/rwa_checker.sv
sim/ring_window_argmin_checker.sv
sim/ring_window_argmin_tb.sv
